// ===== hdl/softened_gravity_body_integrator_macros.svh =====
// Assertion helpers for the body integrator
`ifndef SOFTENED_GRAVITY_BODY_INTEGRATOR_MACROS_SVH
`define SOFTENED_GRAVITY_BODY_INTEGRATOR_MACROS_SVH

`ifndef SYNTH
`define SGBI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgbi check failed");
`define SGBI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgbi check failed");
`else
`define SGBI_ASSERT_NOW(lbl, ante, cons)
`define SGBI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/sgbi_pkg.sv =====
`default_nettype none
package sgbi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DT_BITS   = 16;
  localparam int NUM_W     = 72;   // divider dividend width
  localparam int DIV_CNT_W = 7;
  localparam int SQRT_CNT_W = 5;

  localparam logic REG_BODY_MASS    = 1'b0;
  localparam logic REG_GRAVITY_GAIN = 1'b1;

  typedef enum logic [1:0] {
    OPER_LOAD    = 2'd0,
    OPER_GRAVITY = 2'd1,
    OPER_FORCE   = 2'd2,
    OPER_ADVANCE = 2'd3
  } oper_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_ACCEPT,
    CMD_LOAD,
    CMD_DIFF,
    CMD_SQ_X,
    CMD_SQ_Y,
    CMD_D2,
    CMD_SQRT,
    CMD_GM,
    CMD_DIV_GM,
    CMD_DIV_A,
    CMD_CAP_A,
    CMD_DIV_U,
    CMD_MUL_AL,
    CMD_MUL_AH,
    CMD_ACC_HI,
    CMD_MUL_CL,
    CMD_MUL_CH,
    CMD_G_APPLY,
    CMD_F_MUL,
    CMD_DIV_F,
    CMD_F_APPLY,
    CMD_A_MUL,
    CMD_A_APPLY,
    CMD_PUBLISH
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    axis_y;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
  } dp_status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_G_DIFF,
    ST_G_SQX,
    ST_G_SQY,
    ST_G_D2,
    ST_G_SQRT,
    ST_G_SQRT_WAIT,
    ST_G_GM,
    ST_G_DIV1,
    ST_G_DIV1_WAIT,
    ST_G_DIV2,
    ST_G_DIV2_WAIT,
    ST_G_CAP,
    ST_G_UDIV,
    ST_G_UDIV_WAIT,
    ST_G_MUL_AL,
    ST_G_MUL_AH,
    ST_G_ACC_HI1,
    ST_G_MUL_CL,
    ST_G_MUL_CH,
    ST_G_ACC_HI2,
    ST_G_APPLY,
    ST_F_MUL,
    ST_F_DIV,
    ST_F_DIV_WAIT,
    ST_F_APPLY,
    ST_A_MUL,
    ST_A_APPLY,
    ST_PUBLISH
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/sgbi_ctrl.sv =====
`default_nettype none
module sgbi_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          operation,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sgbi_pkg::dp_cmd_t        cmd,
  input  wire sgbi_pkg::dp_status_t status
);
  import sgbi_pkg::*;

  state_t state, state_next;
  logic   axis_y, axis_y_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis_y    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis_y    <= axis_y_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    axis_y_next    = axis_y;
    out_valid_next = out_valid;
    cmd.op         = CMD_NOP;
    cmd.axis_y     = axis_y;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op      = CMD_ACCEPT;
          axis_y_next = 1'b0;
          case (oper_t'(operation))
            OPER_LOAD:    state_next = ST_LOAD;
            OPER_GRAVITY: state_next = ST_G_DIFF;
            OPER_FORCE:   state_next = ST_F_MUL;
            OPER_ADVANCE: state_next = ST_A_MUL;
            default:      state_next = ST_LOAD;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.op = CMD_LOAD;
        state_next = ST_PUBLISH;
      end
      ST_G_DIFF: begin
        cmd.op = CMD_DIFF;
        state_next = ST_G_SQX;
      end
      ST_G_SQX: begin
        cmd.op = CMD_SQ_X;
        state_next = ST_G_SQY;
      end
      ST_G_SQY: begin
        cmd.op = CMD_SQ_Y;
        state_next = ST_G_D2;
      end
      ST_G_D2: begin
        cmd.op = CMD_D2;
        state_next = ST_G_SQRT;
      end
      ST_G_SQRT: begin
        cmd.op = CMD_SQRT;
        state_next = ST_G_SQRT_WAIT;
      end
      ST_G_SQRT_WAIT: begin
        if (!status.sqrt_busy) state_next = ST_G_GM;
      end
      ST_G_GM: begin
        cmd.op = CMD_GM;
        state_next = ST_G_DIV1;
      end
      ST_G_DIV1: begin
        cmd.op = CMD_DIV_GM;
        state_next = ST_G_DIV1_WAIT;
      end
      ST_G_DIV1_WAIT: begin
        if (!status.div_busy) state_next = ST_G_DIV2;
      end
      ST_G_DIV2: begin
        cmd.op = CMD_DIV_A;
        state_next = ST_G_DIV2_WAIT;
      end
      ST_G_DIV2_WAIT: begin
        if (!status.div_busy) state_next = ST_G_CAP;
      end
      ST_G_CAP: begin
        cmd.op = CMD_CAP_A;
        state_next = ST_G_UDIV;
      end
      ST_G_UDIV: begin
        cmd.op = CMD_DIV_U;
        state_next = ST_G_UDIV_WAIT;
      end
      ST_G_UDIV_WAIT: begin
        if (!status.div_busy) state_next = ST_G_MUL_AL;
      end
      ST_G_MUL_AL: begin
        cmd.op = CMD_MUL_AL;
        state_next = ST_G_MUL_AH;
      end
      ST_G_MUL_AH: begin
        cmd.op = CMD_MUL_AH;
        state_next = ST_G_ACC_HI1;
      end
      ST_G_ACC_HI1: begin
        cmd.op = CMD_ACC_HI;
        state_next = ST_G_MUL_CL;
      end
      ST_G_MUL_CL: begin
        cmd.op = CMD_MUL_CL;
        state_next = ST_G_MUL_CH;
      end
      ST_G_MUL_CH: begin
        cmd.op = CMD_MUL_CH;
        state_next = ST_G_ACC_HI2;
      end
      ST_G_ACC_HI2: begin
        cmd.op = CMD_ACC_HI;
        state_next = ST_G_APPLY;
      end
      ST_G_APPLY: begin
        cmd.op = CMD_G_APPLY;
        if (axis_y) begin
          state_next = ST_PUBLISH;
        end else begin
          axis_y_next = 1'b1;
          state_next  = ST_G_UDIV;
        end
      end
      ST_F_MUL: begin
        cmd.op = CMD_F_MUL;
        state_next = ST_F_DIV;
      end
      ST_F_DIV: begin
        cmd.op = CMD_DIV_F;
        state_next = ST_F_DIV_WAIT;
      end
      ST_F_DIV_WAIT: begin
        if (!status.div_busy) state_next = ST_F_APPLY;
      end
      ST_F_APPLY: begin
        cmd.op = CMD_F_APPLY;
        if (axis_y) begin
          state_next = ST_PUBLISH;
        end else begin
          axis_y_next = 1'b1;
          state_next  = ST_F_MUL;
        end
      end
      ST_A_MUL: begin
        cmd.op = CMD_A_MUL;
        state_next = ST_A_APPLY;
      end
      ST_A_APPLY: begin
        cmd.op = CMD_A_APPLY;
        if (axis_y) begin
          state_next = ST_PUBLISH;
        end else begin
          axis_y_next = 1'b1;
          state_next  = ST_A_MUL;
        end
      end
      ST_PUBLISH: begin
        // output register must be free or emptying this cycle
        if (!out_valid || !out_stall) begin
          cmd.op         = CMD_PUBLISH;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/sgbi_datapath.sv =====
`default_nettype none
module sgbi_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sgbi_pkg::dp_cmd_t    cmd,
  output sgbi_pkg::dp_status_t      status,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic signed [31:0]   arg_x,
  input  wire logic signed [31:0]   arg_y,
  input  wire logic [23:0]          other_mass,
  input  wire logic [15:0]          step_time,
  output logic signed [31:0]        pos_x,
  output logic signed [31:0]        pos_y,
  output logic signed [31:0]        vel_x,
  output logic signed [31:0]        vel_y,
  output logic                      saturated
);
  import sgbi_pkg::*;

  localparam logic signed [32:0] R_CAP = 33'sh0_7FFF_FFFF;
  localparam logic signed [49:0] S_MAX = 50'sd2147483647;
  localparam logic signed [49:0] S_MIN = -50'sd2147483648;
  localparam logic [NUM_W-1:0]   A_CAP = NUM_W'(1) << (62 - FRAC_BITS);
  localparam logic [47:0]        C_CAP = 48'h8000_0000_0000;
  localparam logic [63:0]        SOFT  = 64'd25 << (2 * FRAC_BITS);

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // {clipped flag, value}
  function automatic logic [32:0] clip_r(input logic signed [32:0] d);
    if (d > R_CAP) begin
      clip_r = {1'b1, 32'h7FFF_FFFF};
    end else if (d < -R_CAP) begin
      clip_r = {1'b1, 32'h8000_0001};
    end else begin
      clip_r = {1'b0, d[31:0]};
    end
  endfunction

  function automatic logic [32:0] sat_add(input logic signed [31:0] v,
                                          input logic [47:0] m, input logic neg);
    logic signed [49:0] ve, me, s;
    ve = {{18{v[31]}}, v};
    me = {2'b00, m};
    s  = neg ? (ve - me) : (ve + me);
    if (s > S_MAX) begin
      sat_add = {1'b1, 32'h7FFF_FFFF};
    end else if (s < S_MIN) begin
      sat_add = {1'b1, 32'h8000_0000};
    end else begin
      sat_add = {1'b0, s[31:0]};
    end
  endfunction

  logic signed [31:0] ax, ay;
  logic [23:0]        om;
  logic [15:0]        dt;
  logic [23:0]        body_mass;
  logic [31:0]        gravity_gain;
  logic signed [31:0] px, py, vx, vy, rx, ry;
  logic               flag;
  logic [63:0]        prod, acc;
  logic [46:0]        areg;

  logic [NUM_W-1:0]     dq;
  logic [31:0]          drem, dden;
  logic [DIV_CNT_W-1:0] dcnt;
  logic                 dbusy;

  logic [63:0]           sv, sres, sbit;
  logic [SQRT_CNT_W-1:0] scnt;
  logic                  sbusy;

  logic signed [31:0] sel_r, sel_a, sel_v, sel_p;
  logic [31:0]        ux, uy, ma, mb, d_val;
  logic [63:0]        mprod;
  logic [23:0]        mass_eff;
  logic [32:0]        clip_x, clip_y, sat_res;
  logic [47:0]        c_raw, c_cap;
  logic               c_over;
  logic [32:0]        d_try, d_sub;
  logic               d_ge;
  logic [63:0]        s_trial;
  logic               s_ge;
  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [31:0]        div_den;

  assign sel_r    = cmd.axis_y ? ry : rx;
  assign sel_a    = cmd.axis_y ? ay : ax;
  assign sel_v    = cmd.axis_y ? vy : vx;
  assign sel_p    = cmd.axis_y ? py : px;
  assign ux       = mag32(rx);
  assign uy       = mag32(ry);
  assign d_val    = sres[31:0];
  assign mass_eff = (body_mass == 24'd0) ? 24'd1 : body_mass;
  assign clip_x   = clip_r({ax[31], ax} - {px[31], px});
  assign clip_y   = clip_r({ay[31], ay} - {py[31], py});
  assign c_raw    = acc[63:16];
  assign c_over   = (c_raw > C_CAP);
  assign c_cap    = c_over ? C_CAP : c_raw;

  assign d_try = {drem, dq[NUM_W-1]};
  assign d_ge  = (d_try >= {1'b0, dden});
  assign d_sub = d_try - {1'b0, dden};

  assign s_trial = sres + sbit;
  assign s_ge    = (sv >= s_trial);

  assign status.div_busy  = dbusy;
  assign status.sqrt_busy = sbusy;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      CMD_SQ_X: begin
        ma = ux;
        mb = ux;
      end
      CMD_SQ_Y: begin
        ma = uy;
        mb = uy;
      end
      CMD_GM: begin
        ma = gravity_gain;
        mb = {8'd0, om};
      end
      CMD_MUL_AL: begin
        ma = areg[31:0];
        mb = {15'd0, dq[16:0]};
      end
      CMD_MUL_AH: begin
        ma = {17'd0, areg[46:32]};
        mb = {15'd0, dq[16:0]};
      end
      CMD_MUL_CL: begin
        ma = c_cap[31:0];
        mb = {16'd0, dt};
      end
      CMD_MUL_CH: begin
        ma = {16'd0, acc[47:32]};
        mb = {16'd0, dt};
      end
      CMD_F_MUL: begin
        ma = mag32(sel_a);
        mb = {16'd0, dt};
      end
      CMD_A_MUL: begin
        ma = mag32(sel_v);
        mb = {16'd0, dt};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mprod = {32'd0, ma} * {32'd0, mb};

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = d_val;
    case (cmd.op)
      CMD_DIV_GM: begin
        div_start = 1'b1;
        div_num   = {prod[NUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      end
      CMD_DIV_A: begin
        div_start = 1'b1;
        div_num   = {dq[NUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      end
      CMD_DIV_U: begin
        div_start = 1'b1;
        div_num   = {{(NUM_W-32-FRAC_BITS){1'b0}}, mag32(sel_r), {FRAC_BITS{1'b0}}};
      end
      CMD_DIV_F: begin
        div_start = 1'b1;
        div_num   = {{(NUM_W-64){1'b0}}, prod};
        div_den   = {8'd0, mass_eff};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    sat_res = '0;
    case (cmd.op)
      CMD_G_APPLY: sat_res = sat_add(sel_v, acc[63:16], sel_r[31]);
      CMD_F_APPLY: sat_res = sat_add(sel_v, dq[63:16], sel_a[31]);
      CMD_A_APPLY: sat_res = sat_add(sel_p, prod[63:16], sel_v[31]);
      default:     sat_res = '0;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      body_mass    <= 24'd1;
      gravity_gain <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BODY_MASS:    body_mass    <= cfg_data[23:0];
        REG_GRAVITY_GAIN: gravity_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt  <= '0;
    end else if (div_start) begin
      dq    <= div_num;
      drem  <= '0;
      dden  <= div_den;
      dcnt  <= '0;
      dbusy <= 1'b1;
    end else if (dbusy) begin
      dq   <= {dq[NUM_W-2:0], d_ge};
      drem <= d_ge ? d_sub[31:0] : d_try[31:0];
      dcnt <= dcnt + 1'b1;
      if (dcnt == DIV_CNT_W'(NUM_W - 1)) dbusy <= 1'b0;
    end
  end

  // bit-pair square root, 32 steps
  always_ff @(posedge clk) begin
    if (rst) begin
      sbusy <= 1'b0;
      scnt  <= '0;
    end else if (cmd.op == CMD_SQRT) begin
      sv    <= acc;
      sres  <= '0;
      sbit  <= 64'd1 << 62;
      scnt  <= '0;
      sbusy <= 1'b1;
    end else if (sbusy) begin
      if (s_ge) begin
        sv   <= sv - s_trial;
        sres <= (sres >> 1) + sbit;
      end else begin
        sres <= sres >> 1;
      end
      sbit <= sbit >> 2;
      scnt <= scnt + 1'b1;
      if (scnt == '1) sbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mprod;
    if (rst) begin
      px <= '0;
      py <= '0;
      vx <= '0;
      vy <= '0;
    end else begin
      case (cmd.op)
        CMD_ACCEPT: begin
          ax   <= arg_x;
          ay   <= arg_y;
          om   <= other_mass;
          dt   <= step_time;
          flag <= 1'b0;
        end
        CMD_LOAD: begin
          px <= ax;
          py <= ay;
          vx <= '0;
          vy <= '0;
        end
        CMD_DIFF: begin
          rx   <= clip_x[31:0];
          ry   <= clip_y[31:0];
          flag <= flag | clip_x[32] | clip_y[32];
        end
        CMD_SQ_Y: acc <= prod + SOFT;
        CMD_D2:   acc <= acc + prod;
        CMD_CAP_A: begin
          if (dq > A_CAP) begin
            areg <= A_CAP[46:0];
            flag <= 1'b1;
          end else begin
            areg <= dq[46:0];
          end
        end
        CMD_MUL_AH: acc <= prod;
        CMD_ACC_HI: acc <= acc + {prod[31:0], 32'd0};
        CMD_MUL_CL: begin
          acc  <= {16'd0, c_cap};
          flag <= flag | c_over;
        end
        CMD_MUL_CH: acc <= prod;
        CMD_G_APPLY, CMD_F_APPLY: begin
          if (cmd.axis_y) vy <= sat_res[31:0];
          else vx <= sat_res[31:0];
          flag <= flag | sat_res[32];
        end
        CMD_A_APPLY: begin
          if (cmd.axis_y) py <= sat_res[31:0];
          else px <= sat_res[31:0];
          flag <= flag | sat_res[32];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_PUBLISH) begin
      pos_x     <= px;
      pos_y     <= py;
      vel_x     <= vx;
      vel_y     <= vy;
      saturated <= flag;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/softened_gravity_body_integrator.sv =====
// One item is in flight at a time, the next accepted once it is done. Gravity runs
// the one-bit-a-cycle divider (72 steps, four runs) and the 32-step square root;
// force runs the divider twice. The result sits in an output register, so the
// next item may be taken while it waits.
// Synchronous active-high reset: state to zero, mass 1, gain 1.0, no result pending.
`default_nettype none
`include "softened_gravity_body_integrator_macros.svh"
module softened_gravity_body_integrator (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         operation,
  input  wire logic signed [31:0] arg_x,
  input  wire logic signed [31:0] arg_y,
  input  wire logic [23:0]        other_mass,
  input  wire logic [15:0]        step_time,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [31:0]      vel_x,
  output logic signed [31:0]      vel_y,
  output logic                    saturated,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import sgbi_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  sgbi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  sgbi_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .arg_x      (arg_x),
    .arg_y      (arg_y),
    .other_mass (other_mass),
    .step_time  (step_time),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .vel_x      (vel_x),
    .vel_y      (vel_y),
    .saturated  (saturated)
  );

  `SGBI_ASSERT_NOW(a_idle_units_quiet, !in_stall, !status.div_busy && !status.sqrt_busy)
  `SGBI_ASSERT_NOW(a_one_unit_busy, 1'b1, !(status.div_busy && status.sqrt_busy))
  `SGBI_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule
`default_nettype wire
